@@ sv/block_transfer_receiver_assert.svh @@
// Assertion macros for the block transfer receiver.
// Expects clk and rst in the scope of each use.
`ifndef BLOCK_TRANSFER_RECEIVER_ASSERT_SVH
`define BLOCK_TRANSFER_RECEIVER_ASSERT_SVH

// same-cycle implication
`define BTR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("block_transfer_receiver: same-cycle check failed");

// next-cycle implication
`define BTR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("block_transfer_receiver: next-cycle check failed");

`endif

@@ sv/btr_pkg.sv @@
// Types and constants of the block transfer receiver.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package btr_pkg;

  localparam int          CHUNK_BYTES = 8;
  localparam logic [15:0] HDR_BYTES  = 16'd12;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
  localparam logic [7:0]  BYTE_MASK  = 8'hff;

  localparam logic [23:0] RST_IMAGE_SIZE = 24'd129760;
  localparam logic [23:0] RST_FLASH_BASE = 24'd524288;

  // register indexes
  localparam logic [1:0] CFG_NODE_IS_ROOT = 2'd0;
  localparam logic [1:0] CFG_IMAGE_SIZE   = 2'd1;
  localparam logic [1:0] CFG_FLASH_BASE   = 2'd2;

  // wire message types
  localparam logic [7:0] TYPE_START       = 8'd1;
  localparam logic [7:0] TYPE_START_REPLY = 8'd2;
  localparam logic [7:0] TYPE_DATA        = 8'd3;
  localparam logic [7:0] TYPE_DATA_REPLY  = 8'd4;
  localparam logic [7:0] TYPE_END         = 8'd5;
  localparam logic [7:0] TYPE_END_REPLY   = 8'd6;

  // result status codes
  localparam logic [3:0] ST_NOT_ROOT    = 4'd0;
  localparam logic [3:0] ST_MALFORMED   = 4'd1;
  localparam logic [3:0] ST_BAD_SUM     = 4'd2;
  localparam logic [3:0] ST_WRONG_TOTAL = 4'd3;
  localparam logic [3:0] ST_IGNORED     = 4'd4;
  localparam logic [3:0] ST_START_OK    = 4'd5;
  localparam logic [3:0] ST_STORED      = 4'd6;
  localparam logic [3:0] ST_DUPLICATE   = 4'd7;
  localparam logic [3:0] ST_OUT_OF_ORD  = 4'd8;
  localparam logic [3:0] ST_END_OK      = 4'd9;
  localparam logic [3:0] ST_END_FAIL    = 4'd10;
  localparam logic [3:0] ST_START_REJ   = 4'd11;

  typedef struct packed {
    logic [15:0] packet_length;
    logic [7:0]  msg_type;
    logic [31:0] block_number;
    logic [31:0] total_blocks_field;
    logic [7:0]  payload_length;
    logic [15:0] payload_sum;
    logic [63:0] payload_bytes;
  } btr_pkt_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        reply;
    logic [7:0]  ack_type;
    logic [31:0] ack_block;
    logic        erase_request;
    logic        flash_write;
    logic [23:0] flash_address;
    logic [63:0] flash_data;
    logic [3:0]  flash_byte_count;
  } btr_res_t;

  typedef struct packed {
    logic       start;
    logic [3:0] count;
  } btr_unit_ctl_t;

  typedef struct packed {
    logic        done;
    logic [15:0] sum;
    logic [31:0] hash;
  } btr_unit_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } btr_state_t;

endpackage

`default_nettype wire

@@ sv/btr_if.sv @@
// Channel interfaces of the block transfer receiver: packet in, result out,
// configuration write. Depends on btr_pkg.
`default_nettype none

interface btr_pkt_if import btr_pkg::*; ();
  logic     valid;
  logic     ready;
  btr_pkt_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface btr_res_if import btr_pkg::*; ();
  logic     valid;
  logic     ready;
  btr_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface btr_cfg_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

@@ sv/block_transfer_receiver.sv @@
// Block transfer receiver: one result per packet. A new packet is taken only
// once the last one has been scanned and its result committed; the serial byte
// unit does one sum step and one FNV multiply per byte, scanning no bytes when
// payload_length exceeds the chunk size, and an untaken result stalls the commit.
// Synchronous active-high reset clears the transfer state and loads the
// register defaults; no clearing pass.
`default_nettype none

module block_transfer_receiver import btr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  btr_pkt_if.sink       pkt,
  btr_res_if.source     res,
  btr_cfg_if.sink       cfg
);

  localparam logic [24:0] CHUNK_M1 = 25'(CHUNK_BYTES - 1);
  localparam logic [23:0] TOTAL_RESET =
    24'((int'(RST_IMAGE_SIZE) + CHUNK_BYTES - 1) / CHUNK_BYTES);
  localparam logic [7:0]  CHUNK_LEN = 8'(CHUNK_BYTES);
  localparam logic [23:0] CHUNK_24  = 24'(CHUNK_BYTES);

  // configuration
  logic        node_is_root;
  logic [23:0] image_size_bytes;
  logic [23:0] flash_base_address;
  logic [23:0] block_count;
  logic [24:0] size_round;

  // transfer state
  logic [31:0] next_block, next_block_next;
  logic [31:0] last_good_block, last_good_block_next;
  logic [31:0] bytes_received, bytes_received_next;
  logic [31:0] running_hash, running_hash_next;
  logic [31:0] announced_hash, announced_hash_next;
  logic        transfer_active, transfer_active_next;
  logic        transfer_done, transfer_done_next;

  btr_state_t     state, state_next;
  btr_pkt_t       q;
  btr_unit_ctl_t  u_ctl;
  btr_unit_stat_t u_stat;
  btr_res_t       res_q, res_next;
  logic           res_valid;
  logic           commit;
  logic           accept;

  assign cfg.ready  = !rst;
  assign size_round = {1'b0, cfg.wdata} + CHUNK_M1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_is_root       <= 1'b1;
      image_size_bytes   <= RST_IMAGE_SIZE;
      flash_base_address <= RST_FLASH_BASE;
      block_count        <= TOTAL_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_NODE_IS_ROOT: node_is_root <= cfg.wdata[0];
        CFG_IMAGE_SIZE: begin
          image_size_bytes <= cfg.wdata;
          block_count      <= 24'(size_round / CHUNK_BYTES);
        end
        CFG_FLASH_BASE: flash_base_address <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (pkt.valid) state_next = S_SCAN;
      S_SCAN:   if (u_stat.done) state_next = S_DECIDE;
      S_DECIDE: if (!res_valid || res.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pkt.ready   = 1'b0;
    commit      = 1'b0;
    case (state)
      S_IDLE:   pkt.ready = !rst;
      S_DECIDE: commit = !res_valid || res.ready;
      default:  ;
    endcase
  end

  assign accept      = pkt.valid && pkt.ready;
  assign u_ctl.start = accept;
  // oversize lengths are malformed anyway; scan nothing for them
  assign u_ctl.count = (pkt.data.payload_length > CHUNK_LEN) ? 4'd0
                                                             : pkt.data.payload_length[3:0];

  btr_byte_unit u_bytes (
    .clk       (clk),
    .rst       (rst),
    .ctl       (u_ctl),
    .bytes_in  (pkt.data.payload_bytes),
    .hash_init (running_hash),
    .stat      (u_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (accept) q <= pkt.data;
  end

  // ---------------- packet decision ----------------
  logic        malformed;
  logic [15:0] plen_expect;
  logic [31:0] meta_size;
  logic [31:0] meta_hash;
  logic [31:0] size_32;
  logic [31:0] block_m1;
  logic [23:0] addr_off;
  logic [63:0] inv_data;

  assign plen_expect = HDR_BYTES + {8'd0, q.payload_length};
  assign malformed   = (q.packet_length < HDR_BYTES) || (q.payload_length > CHUNK_LEN) ||
                       (q.packet_length != plen_expect);
  assign meta_size   = q.payload_bytes[63:32];
  assign meta_hash   = q.payload_bytes[31:0];
  assign size_32     = {8'd0, image_size_bytes};
  assign block_m1    = q.block_number - 32'd1;
  assign addr_off    = block_m1[23:0] * CHUNK_24;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < q.payload_length[3:0])
        inv_data[63 - 8*i -: 8] = q.payload_bytes[63 - 8*i -: 8] ^ BYTE_MASK;
      else
        inv_data[63 - 8*i -: 8] = 8'h00;
    end
  end

  always_comb begin
    next_block_next      = next_block;
    last_good_block_next = last_good_block;
    bytes_received_next  = bytes_received;
    running_hash_next    = running_hash;
    announced_hash_next  = announced_hash;
    transfer_active_next = transfer_active;
    transfer_done_next   = transfer_done;
    res_next             = '0;
    res_next.status      = ST_IGNORED;

    if (!node_is_root) begin
      res_next.status = ST_NOT_ROOT;
    end else if (malformed) begin
      res_next.status = ST_MALFORMED;
    end else if (u_stat.sum != q.payload_sum) begin
      res_next.status = ST_BAD_SUM;
    end else if (q.total_blocks_field != {8'd0, block_count}) begin
      res_next.status = ST_WRONG_TOTAL;
    end else if (q.msg_type == TYPE_START) begin
      res_next.status = ST_START_REJ;
      if (q.payload_length == CHUNK_LEN) begin
        announced_hash_next = meta_hash;
        if (meta_size == size_32) begin
          // no re-arm once the transfer has moved past block 1
          if (!transfer_active || next_block == 32'd1) begin
            next_block_next        = 32'd1;
            last_good_block_next   = 32'd0;
            bytes_received_next    = 32'd0;
            running_hash_next      = FNV_BASIS;
            transfer_active_next   = 1'b1;
            transfer_done_next     = 1'b0;
            res_next.erase_request = 1'b1;
          end
          res_next.status   = ST_START_OK;
          res_next.reply    = 1'b1;
          res_next.ack_type = TYPE_START_REPLY;
        end
      end
    end else if (q.msg_type == TYPE_DATA) begin
      if (!transfer_active || transfer_done) begin
        res_next.status = ST_IGNORED;
      end else if (q.block_number == last_good_block) begin
        res_next.status    = ST_DUPLICATE;
        res_next.reply     = 1'b1;
        res_next.ack_type  = TYPE_DATA_REPLY;
        res_next.ack_block = q.block_number;
      end else if (q.block_number != next_block) begin
        res_next.status = ST_OUT_OF_ORD;
        if (last_good_block != 32'd0) begin
          res_next.reply     = 1'b1;
          res_next.ack_type  = TYPE_DATA_REPLY;
          res_next.ack_block = last_good_block;
        end
      end else begin
        res_next.status           = ST_STORED;
        res_next.reply            = 1'b1;
        res_next.ack_type         = TYPE_DATA_REPLY;
        res_next.ack_block        = q.block_number;
        res_next.flash_write      = 1'b1;
        res_next.flash_address    = flash_base_address + addr_off;
        res_next.flash_data       = inv_data;
        res_next.flash_byte_count = q.payload_length[3:0];
        running_hash_next         = u_stat.hash;
        bytes_received_next       = bytes_received + {24'd0, q.payload_length};
        last_good_block_next      = q.block_number;
        next_block_next           = next_block + 32'd1;
      end
    end else if (q.msg_type == TYPE_END) begin
      if (!transfer_active || q.payload_length != CHUNK_LEN) begin
        res_next.status = ST_IGNORED;
      end else if (last_good_block == {8'd0, block_count} &&
                   bytes_received == size_32 && meta_size == size_32 &&
                   meta_hash == announced_hash && running_hash == announced_hash) begin
        transfer_done_next = 1'b1;
        res_next.status    = ST_END_OK;
        res_next.reply     = 1'b1;
        res_next.ack_type  = TYPE_END_REPLY;
        res_next.ack_block = {8'd0, block_count};
      end else begin
        transfer_active_next = 1'b0;
        res_next.status      = ST_END_FAIL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_block      <= 32'd0;
      last_good_block <= 32'd0;
      bytes_received  <= 32'd0;
      running_hash    <= 32'd0;
      announced_hash  <= 32'd0;
      transfer_active <= 1'b0;
      transfer_done   <= 1'b0;
    end else if (commit) begin
      next_block      <= next_block_next;
      last_good_block <= last_good_block_next;
      bytes_received  <= bytes_received_next;
      running_hash    <= running_hash_next;
      announced_hash  <= announced_hash_next;
      transfer_active <= transfer_active_next;
      transfer_done   <= transfer_done_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) res_q <= res_next;
  end

  assign res.valid = res_valid;
  assign res.data  = res_q;

  // ---------------- assertions ----------------
`include "block_transfer_receiver_assert.svh"

  `BTR_ASSERT_NEXT(a_busy_after_accept, pkt.valid && pkt.ready, !pkt.ready)
  `BTR_ASSERT_IMPL(a_unit_done_in_scan, u_stat.done, state == S_SCAN)
  `BTR_ASSERT_IMPL(a_write_only_stored, res.valid && res.data.flash_write,
                   res.data.status == ST_STORED && res.data.reply)
  `BTR_ASSERT_IMPL(a_erase_only_start, res.valid && res.data.erase_request,
                   res.data.status == ST_START_OK && !res.data.flash_write)

endmodule

`default_nettype wire

@@ sv/btr_byte_unit.sv @@
// Serial byte unit: one payload byte per cycle into a 16-bit sum and an
// FNV-1a hash through a single 32x32 multiplier. Depends on btr_pkg.
`default_nettype none

module btr_byte_unit import btr_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  btr_unit_ctl_t  ctl,
  input  logic [63:0]    bytes_in,
  input  logic [31:0]    hash_init,
  output btr_unit_stat_t stat
);

  logic [63:0] shreg;
  logic [3:0]  cnt;
  logic        busy;
  logic        done;
  logic [15:0] sum;
  logic [31:0] hash;
  logic [7:0]  cur;
  logic [31:0] mixed;
  logic [31:0] prod;

  assign cur   = shreg[63:56];
  assign mixed = hash ^ {24'd0, cur};
  assign prod  = mixed * FNV_PRIME;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 4'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      shreg <= bytes_in;
      cnt   <= ctl.count;
      sum   <= 16'd0;
      hash  <= hash_init;
    end else if (busy && cnt != 4'd0) begin
      shreg <= {shreg[55:0], 8'h00};
      cnt   <= cnt - 4'd1;
      sum   <= sum + {8'd0, cur};
      hash  <= prod;
    end
  end

  assign stat.done = done;
  assign stat.sum  = sum;
  assign stat.hash = hash;

endmodule

`default_nettype wire

@@ bench/tb_block_transfer_receiver.sv @@
// Testbench for block_transfer_receiver: random bursty packet driver, stalling result
// monitor and a cycle-free predictor of the transfer state machine.
// Depends on btr_pkg, the channel interfaces in btr_if.sv and the RTL top level.
`timescale 1ns / 100ps

module tb_block_transfer_receiver;
  import btr_pkg::*;

  localparam logic [31:0] CHUNK = 32'(CHUNK_BYTES);
  localparam int SETTLE_CYCLES = 16;

  typedef enum logic [1:0] {PLAN_PKT, PLAN_CFG, PLAN_SYNC} plan_kind_t;
  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_LONG} rdy_mode_t;
  typedef enum logic [2:0] {
    GL_DUP, GL_SKIP_AHEAD, GL_BAD_SUM, GL_BAD_TOTAL, GL_MALFORMED, GL_RESTART
  } glitch_t;

  typedef struct {
    plan_kind_t  kind;
    btr_pkt_t    pkt;
    logic [1:0]  idx;
    logic [23:0] val;
  } plan_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  btr_pkt_if pkt_if ();
  btr_res_if res_if ();
  btr_cfg_if cfg_if ();

  logic        pkt_vld = 1'b0;
  btr_pkt_t    pkt_dat = '0;
  logic        cfg_vld = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [23:0] cfg_dat = '0;
  logic        res_rdy = 1'b0;

  assign pkt_if.valid = pkt_vld;
  assign pkt_if.data  = pkt_dat;
  assign cfg_if.valid = cfg_vld;
  assign cfg_if.index = cfg_idx;
  assign cfg_if.wdata = cfg_dat;
  assign res_if.ready = res_rdy;

  block_transfer_receiver dut (
    .clk (clk),
    .rst (rst),
    .pkt (pkt_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  // predictor copy of registers and transfer state
  logic        is_root    = 1'b1;
  logic [23:0] img_size   = RST_IMAGE_SIZE;
  logic [23:0] flash_base = RST_FLASH_BASE;
  logic [31:0] nxt_blk    = '0;
  logic [31:0] good_blk   = '0;
  logic [31:0] rx_bytes   = '0;
  logic [31:0] img_hash   = '0;
  logic [31:0] ann_hash   = '0;
  logic        xfer_on    = 1'b0;
  logic        xfer_fin   = 1'b0;

  plan_t    pkt_plan [$];
  btr_res_t due_results [$];
  int       mism = 0;

  // stimulus-side view of the configuration
  logic [23:0] g_size;
  logic [31:0] g_tot;
  int          main_cnt = 0;

  function automatic logic [15:0] payload_sum_of(input logic [63:0] d, input logic [7:0] len);
    logic [15:0] s;
    s = '0;
    for (int i = 0; i < len && i < 8; i++) s = s + {8'd0, d[63 - 8*i -: 8]};
    return s;
  endfunction

  function automatic logic [31:0] fnv1a_fold(input logic [31:0] h, input logic [63:0] d,
                                             input logic [7:0] len);
    for (int i = 0; i < len && i < 8; i++) h = (h ^ {24'd0, d[63 - 8*i -: 8]}) * FNV_PRIME;
    return h;
  endfunction

  function automatic btr_res_t predict_reply(input btr_pkt_t p);
    btr_res_t    r;
    logic [31:0] tot, msize, mhash, addr;
    r = '0;
    r.status = ST_IGNORED;
    tot = ({8'd0, img_size} + CHUNK - 32'd1) / CHUNK;
    msize = p.payload_bytes[63:32];
    mhash = p.payload_bytes[31:0];
    if (!is_root) begin
      r.status = ST_NOT_ROOT;
    end else if (p.packet_length < HDR_BYTES || p.payload_length > CHUNK ||
                 p.packet_length != HDR_BYTES + p.payload_length) begin
      r.status = ST_MALFORMED;
    end else if (payload_sum_of(p.payload_bytes, p.payload_length) != p.payload_sum) begin
      r.status = ST_BAD_SUM;
    end else if (p.total_blocks_field != tot) begin
      r.status = ST_WRONG_TOTAL;
    end else begin
      case (p.msg_type)
        TYPE_START: begin
          r.status = ST_START_REJ;
          if (p.payload_length == CHUNK) begin
            ann_hash = mhash;
            if (msize == {8'd0, img_size}) begin
              // a transfer already past block 1 is acked but not restarted
              if (!xfer_on || nxt_blk == 32'd1) begin
                nxt_blk  = 32'd1;
                good_blk = '0;
                rx_bytes = '0;
                img_hash = FNV_BASIS;
                xfer_on  = 1'b1;
                xfer_fin = 1'b0;
                r.erase_request = 1'b1;
              end
              r.status   = ST_START_OK;
              r.reply    = 1'b1;
              r.ack_type = TYPE_START_REPLY;
            end
          end
        end
        TYPE_DATA: begin
          if (!xfer_on || xfer_fin) begin
            r.status = ST_IGNORED;
          end else if (p.block_number == good_blk) begin
            r.status    = ST_DUPLICATE;
            r.reply     = 1'b1;
            r.ack_type  = TYPE_DATA_REPLY;
            r.ack_block = p.block_number;
          end else if (p.block_number != nxt_blk) begin
            r.status = ST_OUT_OF_ORD;
            if (good_blk != 0) begin
              r.reply     = 1'b1;
              r.ack_type  = TYPE_DATA_REPLY;
              r.ack_block = good_blk;
            end
          end else begin
            addr = {8'd0, flash_base} + (p.block_number - 32'd1) * CHUNK;
            r.flash_write      = 1'b1;
            r.flash_address    = addr[23:0];
            r.flash_byte_count = p.payload_length[3:0];
            for (int i = 0; i < p.payload_length; i++)
              r.flash_data[63 - 8*i -: 8] = ~p.payload_bytes[63 - 8*i -: 8];
            img_hash  = fnv1a_fold(img_hash, p.payload_bytes, p.payload_length);
            rx_bytes  = rx_bytes + {24'd0, p.payload_length};
            good_blk  = p.block_number;
            nxt_blk   = nxt_blk + 32'd1;
            r.status    = ST_STORED;
            r.reply     = 1'b1;
            r.ack_type  = TYPE_DATA_REPLY;
            r.ack_block = p.block_number;
          end
        end
        TYPE_END: begin
          if (xfer_on && p.payload_length == CHUNK) begin
            if (good_blk == tot && rx_bytes == {8'd0, img_size} &&
                msize == {8'd0, img_size} && mhash == ann_hash && img_hash == ann_hash) begin
              xfer_fin    = 1'b1;
              r.status    = ST_END_OK;
              r.reply     = 1'b1;
              r.ack_type  = TYPE_END_REPLY;
              r.ack_block = tot;
            end else begin
              xfer_on  = 1'b0;
              r.status = ST_END_FAIL;
            end
          end
        end
        default: r.status = ST_IGNORED;
      endcase
    end
    return r;
  endfunction

  function automatic void write_shadow(input logic [1:0] idx, input logic [23:0] v);
    case (idx)
      CFG_NODE_IS_ROOT: is_root = v[0];
      CFG_IMAGE_SIZE:   img_size = v;
      CFG_FLASH_BASE:   flash_base = v;
      default: ;
    endcase
  endfunction

  function automatic string res_diff(input btr_res_t w, input btr_res_t g);
    string s;
    s = "";
    if (g.status !== w.status)                     s = {s, " status"};
    if (g.reply !== w.reply)                       s = {s, " reply"};
    if (g.ack_type !== w.ack_type)                 s = {s, " ack_type"};
    if (g.ack_block !== w.ack_block)               s = {s, " ack_block"};
    if (g.erase_request !== w.erase_request)       s = {s, " erase_request"};
    if (g.flash_write !== w.flash_write)           s = {s, " flash_write"};
    if (g.flash_address !== w.flash_address)       s = {s, " flash_address"};
    if (g.flash_data !== w.flash_data)             s = {s, " flash_data"};
    if (g.flash_byte_count !== w.flash_byte_count) s = {s, " flash_byte_count"};
    return s;
  endfunction

  function automatic btr_pkt_t mk_pkt(input logic [7:0] typ, input logic [31:0] blk,
                                      input logic [31:0] tot, input logic [7:0] len,
                                      input logic [63:0] d);
    btr_pkt_t p;
    p.packet_length      = HDR_BYTES + {8'd0, len};
    p.msg_type           = typ;
    p.block_number       = blk;
    p.total_blocks_field = tot;
    p.payload_length     = len;
    p.payload_sum        = payload_sum_of(d, len);
    p.payload_bytes      = d;
    return p;
  endfunction

  task automatic push_pkt(input btr_pkt_t p, input bit counted);
    plan_t e;
    e.kind = PLAN_PKT;
    e.pkt  = p;
    e.idx  = '0;
    e.val  = '0;
    pkt_plan.push_back(e);
    if (counted) main_cnt++;
  endtask

  // register writes only go out once the block has drained
  task automatic push_cfg(input logic [1:0] idx, input logic [23:0] v);
    plan_t e;
    e.kind = PLAN_SYNC;
    e.pkt  = '0;
    e.idx  = '0;
    e.val  = '0;
    pkt_plan.push_back(e);
    e.kind = PLAN_CFG;
    e.idx  = idx;
    e.val  = v;
    pkt_plan.push_back(e);
    if (idx == CFG_IMAGE_SIZE) begin
      g_size = v;
      g_tot  = ({8'd0, v} + CHUNK - 32'd1) / CHUNK;
    end
  endtask

  task automatic push_noise();
    btr_pkt_t    p;
    logic [7:0]  len;
    logic [63:0] d;
    len = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
    d = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: p = mk_pkt(8'($urandom), $urandom, g_tot, len, d);
      1: p = mk_pkt(TYPE_START, $urandom, g_tot, len, d);
      2: p = mk_pkt(TYPE_DATA, $urandom_range(0, 4), g_tot, len, d);
      default: p = mk_pkt(TYPE_END, $urandom, g_tot, len, d);
    endcase
    if ($urandom_range(0, 3) == 0) p.packet_length = 16'($urandom);
    if ($urandom_range(0, 3) == 0) p.total_blocks_field = $urandom;
    if ($urandom_range(0, 3) == 0) p.payload_sum = 16'($urandom);
    push_pkt(p, 1'b0);
  endtask

  task automatic push_glitch(input logic [31:0] blk, input logic [63:0] d, input int ln,
                             input logic [31:0] h);
    btr_pkt_t p;
    glitch_t  g;
    g = glitch_t'($urandom_range(0, 5));
    p = mk_pkt(TYPE_DATA, blk, g_tot, 8'(ln), d);
    case (g)
      GL_DUP:        p = mk_pkt(TYPE_DATA, blk - 32'd1, g_tot, 8'd8, {$urandom, $urandom});
      GL_SKIP_AHEAD: p.block_number = ($urandom_range(0, 1) == 0) ? blk + 32'd1 : $urandom;
      GL_BAD_SUM:    p.payload_sum = p.payload_sum ^ (16'd1 << $urandom_range(0, 15));
      GL_BAD_TOTAL:  p.total_blocks_field = g_tot + 32'd1 + $urandom_range(0, 3);
      GL_MALFORMED:  p.packet_length = p.packet_length + 16'd1;
      default:       p = mk_pkt(TYPE_START, 32'd0, g_tot, 8'd8, {8'd0, g_size, h});
    endcase
    push_pkt(p, 1'b1);
  endtask

  // one START / DATA / END sequence for the configured size, at most 12 data blocks; messy ones add faults
  task automatic gen_transfer(input bit messy);
    logic [63:0] blk_dat [$];
    int          blk_len [$];
    logic [31:0] h, nblk;
    logic [63:0] d;
    int          ln;
    h = FNV_BASIS;
    nblk = (g_tot > 32'd12) ? 32'd12 : g_tot;
    for (int b = 0; b < nblk; b++) begin
      ln = (b == g_tot - 1) ? int'(g_size) - 8 * (int'(g_tot) - 1) : 8;
      if (messy && $urandom_range(0, 15) == 0) ln = $urandom_range(0, 8);
      d = {$urandom, $urandom};
      h = fnv1a_fold(h, d, 8'(ln));
      blk_dat.push_back(d);
      blk_len.push_back(ln);
    end
    if (messy && $urandom_range(0, 4) == 0)
      push_pkt(mk_pkt(TYPE_START, 32'd0, g_tot, 8'd8, {8'd0, g_size, $urandom}), 1'b1);
    if (messy && $urandom_range(0, 5) == 0)
      push_pkt(mk_pkt(TYPE_START, 32'd0, g_tot, 8'd4, {8'd0, g_size, h}), 1'b1);
    push_pkt(mk_pkt(TYPE_START, 32'd0, g_tot, 8'd8, {8'd0, g_size, h}), 1'b1);
    for (int b = 0; b < nblk; b++) begin
      if (messy && $urandom_range(0, 3) == 0) push_glitch(b + 1, blk_dat[b], blk_len[b], h);
      if (!(messy && $urandom_range(0, 19) == 0))
        push_pkt(mk_pkt(TYPE_DATA, b + 1, g_tot, 8'(blk_len[b]), blk_dat[b]), 1'b1);
    end
    d = {8'd0, g_size, h};
    if (messy && $urandom_range(0, 5) == 0) d[31:0] = d[31:0] ^ ($urandom | 32'd1);
    push_pkt(mk_pkt(TYPE_END, $urandom, g_tot, 8'd8, d), 1'b1);
    if (messy && $urandom_range(0, 3) == 0) begin
      push_pkt(mk_pkt(TYPE_DATA, nblk + 1, g_tot, 8'd8, {$urandom, $urandom}), 1'b1);
      push_pkt(mk_pkt(TYPE_END, 32'd0, g_tot, 8'd8, d), 1'b1);
    end
  endtask

  // packet / config driver
  int burst_left = 4;
  int gap_left   = 0;
  int settle_cnt = 0;

  always @(posedge clk) begin : drive
    logic nv_pkt, nv_cfg;
    if (rst) begin
      pkt_vld <= 1'b0;
      cfg_vld <= 1'b0;
    end else begin
      nv_pkt = pkt_vld;
      nv_cfg = cfg_vld;
      if (pkt_vld && pkt_if.ready) begin
        due_results.push_back(predict_reply(pkt_dat));
        nv_pkt = 1'b0;
      end
      if (cfg_vld && cfg_if.ready) begin
        write_shadow(cfg_idx, cfg_dat);
        nv_cfg = 1'b0;
      end
      if (!nv_pkt && !nv_cfg && pkt_plan.size() != 0) begin
        case (pkt_plan[0].kind)
          PLAN_PKT: begin
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              pkt_dat <= pkt_plan[0].pkt;
              nv_pkt = 1'b1;
              pkt_plan.delete(0);
              if (burst_left > 1) begin
                burst_left--;
              end else begin
                burst_left = $urandom_range(1, 16);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
              end
            end
          end
          PLAN_CFG: begin
            cfg_idx <= pkt_plan[0].idx;
            cfg_dat <= pkt_plan[0].val;
            nv_cfg = 1'b1;
            pkt_plan.delete(0);
          end
          default: begin
            // hold off until every transaction has come back, then let it settle
            if (due_results.size() != 0) begin
              settle_cnt = 0;
            end else if (settle_cnt == SETTLE_CYCLES) begin
              settle_cnt = 0;
              pkt_plan.delete(0);
            end else begin
              settle_cnt++;
            end
          end
        endcase
      end
      pkt_vld <= nv_pkt;
      cfg_vld <= nv_cfg;
    end
  end

  // result monitor and ready pattern
  rdy_mode_t  rdy_mode  = RDY_ALWAYS;
  int         rdy_left  = 0;
  int         hold_left = 0;
  logic [7:0] rdy_tick  = '0;

  always @(posedge clk) begin : observe
    btr_res_t want;
    string    diff;
    logic     nr;
    if (rst) begin
      res_rdy <= 1'b0;
    end else begin
      if (res_if.valid && res_rdy) begin
        if (due_results.size() == 0) begin
          mism++;
          if (mism <= 10) $display("unexpected result: got %h", res_if.data);
        end else begin
          want = due_results.pop_front();
          diff = res_diff(want, res_if.data);
          if (diff != "") begin
            mism++;
            if (mism <= 10)
              $display("result mismatch in%s: expected %h got %h", diff, want, res_if.data);
          end
        end
      end
      if (rdy_left == 0) begin
        rdy_mode = rdy_mode_t'($urandom_range(0, 3));
        rdy_left = $urandom_range(30, 150);
      end else begin
        rdy_left--;
      end
      rdy_tick++;
      case (rdy_mode)
        RDY_ALWAYS: nr = 1'b1;
        RDY_COIN:   nr = 1'($urandom_range(0, 1));
        RDY_SPARSE: nr = (rdy_tick[1:0] == 2'd0);
        default: begin
          if (hold_left != 0) begin
            hold_left--;
            nr = 1'b0;
          end else begin
            nr = 1'b1;
            hold_left = $urandom_range(5, 20);
          end
        end
      endcase
      res_rdy <= nr;
    end
  end

  initial begin : timeout
    #3_000_000;
    $display("block_transfer_receiver verification failed");
    $finish;
  end

  initial begin : stim
    logic [31:0] tot0, h;
    logic [63:0] d1, d2, d3, meta;
    btr_pkt_t    p;
    g_size = RST_IMAGE_SIZE;
    g_tot  = ({8'd0, RST_IMAGE_SIZE} + CHUNK - 32'd1) / CHUNK;
    tot0   = g_tot;

    // directed: screening checks at reset configuration
    p = mk_pkt(TYPE_START, 32'd0, tot0, 8'd0, 64'd0);
    p.packet_length = 16'd0;
    push_pkt(p, 1'b1);
    p = mk_pkt(TYPE_DATA, 32'd1, tot0, 8'd8, {$urandom, $urandom});
    p.packet_length  = 16'hffff;
    p.payload_length = 8'hff;
    push_pkt(p, 1'b1);
    push_pkt(mk_pkt(TYPE_DATA, 32'd1, tot0, 8'd9, {$urandom, $urandom}), 1'b1);
    p = mk_pkt(TYPE_DATA, 32'd1, tot0, 8'd8, 64'd0);
    p.payload_sum = 16'hffff;
    push_pkt(p, 1'b1);
    push_pkt(mk_pkt(TYPE_START, 32'd0, 32'hffffffff, 8'd8, {32'd129760, $urandom}), 1'b1);
    push_pkt(mk_pkt(TYPE_DATA, 32'd1, tot0, 8'd8, {$urandom, $urandom}), 1'b1);
    push_pkt(mk_pkt(TYPE_END, 32'd0, tot0, 8'd8, {32'd129760, $urandom}), 1'b1);
    push_pkt(mk_pkt(8'd0, 32'd0, tot0, 8'd0, 64'd0), 1'b1);
    push_pkt(mk_pkt(8'hff, 32'hffffffff, tot0, 8'd8, 64'hffffffffffffffff), 1'b1);
    push_pkt(mk_pkt(TYPE_START, 32'd0, tot0, 8'd4, {32'd129760, $urandom}), 1'b1);
    push_pkt(mk_pkt(TYPE_START, 32'd0, tot0, 8'd8, {32'd5, $urandom}), 1'b1);

    // directed: 20-byte image in three blocks, flash address wrapping past the top
    push_cfg(CFG_IMAGE_SIZE, 24'd20);
    push_cfg(CFG_FLASH_BASE, 24'hfffffc);
    d1 = {$urandom, $urandom};
    d2 = {$urandom, $urandom};
    d3 = {$urandom, $urandom};
    h = fnv1a_fold(fnv1a_fold(fnv1a_fold(FNV_BASIS, d1, 8'd8), d2, 8'd8), d3, 8'd4);
    meta = {32'd20, h};
    push_pkt(mk_pkt(TYPE_START, 32'd0, g_tot, 8'd8, meta), 1'b1);
    push_pkt(mk_pkt(TYPE_DATA, 32'd0, g_tot, 8'd8, d1), 1'b1);
    push_pkt(mk_pkt(TYPE_DATA, 32'd2, g_tot, 8'd8, d2), 1'b1);
    push_pkt(mk_pkt(TYPE_DATA, 32'd1, g_tot, 8'd8, d1), 1'b1);
    push_pkt(mk_pkt(TYPE_DATA, 32'd1, g_tot, 8'd8, d1), 1'b1);
    push_pkt(mk_pkt(TYPE_DATA, 32'd3, g_tot, 8'd4, d3), 1'b1);
    push_pkt(mk_pkt(TYPE_START, 32'd0, g_tot, 8'd8, meta), 1'b1);
    push_pkt(mk_pkt(TYPE_DATA, 32'd2, g_tot, 8'd8, d2), 1'b1);
    push_pkt(mk_pkt(TYPE_DATA, 32'hffffffff, g_tot, 8'd8, d2), 1'b1);
    push_pkt(mk_pkt(TYPE_END, 32'd0, g_tot, 8'd4, meta), 1'b1);
    push_pkt(mk_pkt(TYPE_DATA, 32'd3, g_tot, 8'd4, d3), 1'b1);
    push_pkt(mk_pkt(TYPE_END, 32'd0, g_tot, 8'd8, meta), 1'b1);
    push_pkt(mk_pkt(TYPE_DATA, 32'd4, g_tot, 8'd8, d1), 1'b1);
    push_pkt(mk_pkt(TYPE_END, 32'd0, g_tot, 8'd8, {32'd20, ~h}), 1'b1);
    push_cfg(CFG_NODE_IS_ROOT, 24'd0);
    push_pkt(mk_pkt(TYPE_DATA, 32'd1, g_tot, 8'd8, d1), 1'b1);
    push_cfg(CFG_NODE_IS_ROOT, 24'd1);

    // register extremes
    push_cfg(CFG_IMAGE_SIZE, 24'hffffff);
    push_cfg(CFG_FLASH_BASE, 24'd0);
    gen_transfer(1'b0);
    push_cfg(CFG_IMAGE_SIZE, 24'd1);
    push_cfg(CFG_FLASH_BASE, 24'hffffff);
    gen_transfer(1'b0);

    // random phases: mostly well-formed transfers with random content
    while (main_cnt < 400) begin
      case ($urandom_range(0, 9))
        0:       push_cfg(CFG_IMAGE_SIZE, 24'd1);
        1:       push_cfg(CFG_IMAGE_SIZE, 24'($urandom_range(81, 400)));
        default: push_cfg(CFG_IMAGE_SIZE, 24'($urandom_range(1, 80)));
      endcase
      case ($urandom_range(0, 9))
        0:       push_cfg(CFG_FLASH_BASE, 24'd0);
        1:       push_cfg(CFG_FLASH_BASE, 24'hffffff);
        default: push_cfg(CFG_FLASH_BASE, 24'($urandom));
      endcase
      if ($urandom_range(0, 7) == 0) begin
        push_cfg(CFG_NODE_IS_ROOT, 24'd0);
        repeat ($urandom_range(2, 5)) push_noise();
        push_cfg(CFG_NODE_IS_ROOT, 24'd1);
      end
      repeat ($urandom_range(1, 3)) begin
        gen_transfer($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) push_noise();
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pkt_plan.size() != 0 || pkt_vld || cfg_vld || due_results.size() != 0)
      @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mism == 0)
      $display("block_transfer_receiver verification clean");
    else
      $display("block_transfer_receiver verification failed");
    $finish;
  end

endmodule

@@ block_transfer_receiver.f @@
+incdir+sv
sv/btr_pkg.sv
sv/btr_if.sv
sv/btr_byte_unit.sv
sv/block_transfer_receiver.sv
bench/tb_block_transfer_receiver.sv
